FILE: design/hhpi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heading-hold PI controller.
// Used by hhpi_ser_mul and heading_hold_pi_controller_unit; no dependencies.
package hhpi_pkg;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_FACTOR   = 3'd4;

    localparam longint PI_Q16 = 205887;
    localparam int INTEG_W = 32;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_err_sign;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic                      done;
        logic signed [MUL_P_W-1:0] product;
    } t_mul_rsp;

    // floor((p + 128) / 256)
    function automatic logic signed [MUL_P_W-9:0] round_sh8(
        input logic signed [MUL_P_W-1:0] p
    );
        logic signed [MUL_P_W-1:0] t;
        t = p + MUL_P_W'(128);
        return t[MUL_P_W-1:8];
    endfunction

endpackage

FILE: design/hhpi_ser_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: signed parallel operand times unsigned
// operand taken one bit per cycle, LSB first. Depends on hhpi_pkg.
module hhpi_ser_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hhpi_pkg::t_mul_req i_req,
    output hhpi_pkg::t_mul_rsp o_rsp
);
    import hhpi_pkg::*;

    logic signed [MUL_A_W-1:0] r_a;
    logic signed [MUL_A_W:0]   r_hi;
    logic signed [MUL_A_W:0]   n_sum;
    logic [MUL_B_W-1:0]        r_lo;
    logic [MUL_CNT_W-1:0]      r_cnt;
    logic                      r_busy;
    logic                      r_done;

    always_comb begin
        n_sum = r_hi + (r_lo[0] ? (MUL_A_W+1)'(r_a) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_busy) begin
            r_hi <= n_sum >>> 1;
            r_lo <= {n_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi[MUL_A_W-1:0], r_lo};

endmodule

FILE: design/heading_hold_pi_controller_unit.sv
`timescale 1ns / 1ps
// Heading-hold PI controller with a leaky integral: top level and sequencer.
// Depends on hhpi_pkg and hhpi_ser_mul.
//
// One item (heading, dt) gives one result (left and right wheel commands and the
// wrapped heading error). Items are handled one at a time: no new item is accepted
// until the result of the accepted one is in the output register, and the next item is
// accepted in the cycle after that, even if the previous result is still waiting
// to be taken. The pace is set by the single shared bit-serial multiplier, which
// runs four passes per item (integral times leak, error times dt, error times
// proportional gain, integral times integral gain); the error is formed before the
// first pass, the integral is updated before the third, and the commands are formed
// after the last. A result still waiting when the next one is
// ready holds the sequencer until it is taken. Configuration writes are always
// taken and must only be made while idle.
module heading_hold_pi_controller_unit #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int DRIVE_LIMIT     = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [15:0]                         i_heading,
    input  logic [15:0]                         i_dt_fraction,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [7:0]                   o_left_drive,
    output logic signed [7:0]                   o_right_drive,
    output logic signed [15:0]                  o_heading_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hhpi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hhpi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hhpi_pkg::*;

    localparam longint HALF_TURN = ((PI_Q16 << ANGLE_FRAC_BITS) + 32768) >>> 16;
    localparam int ERR_W  = $clog2(65535 + 2 * HALF_TURN + 1) + 1;
    localparam int SH     = ANGLE_FRAC_BITS + 16;
    localparam int PE_W   = ERR_W + 11;
    localparam int CORR_W = ERR_W + 28;
    localparam int DRV_W  = CORR_W + 2;
    localparam int ACC_W  = 35;
    localparam int RND_W  = MUL_P_W - 8;

    localparam logic signed [ERR_W-1:0] HALF_S = ERR_W'(HALF_TURN);
    localparam logic signed [ERR_W-1:0] FULL_S = ERR_W'(2 * HALF_TURN);
    localparam logic signed [ERR_W-1:0] E_MAX  = ERR_W'(32767);
    localparam logic signed [ERR_W-1:0] E_MIN  = ERR_W'(-32768);
    localparam logic signed [ACC_W-1:0] I_MAX  = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] I_MIN  = ACC_W'(-64'sd2147483648);
    localparam logic signed [DRV_W-1:0] LIM_P  = DRV_W'(DRIVE_LIMIT);
    localparam logic signed [DRV_W-1:0] LIM_N  = DRV_W'(-DRIVE_LIMIT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_LEAK,
        S_EDT,
        S_ACC,
        S_PROP,
        S_INTEG,
        S_SUM,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [15:0]               r_start_heading;
    logic signed [7:0]         r_base_speed;
    logic [9:0]                r_prop_gain;
    logic [7:0]                r_integ_gain;
    logic [8:0]                r_leak_factor;
    logic signed [INTEG_W-1:0] r_integ;
    t_err_sign                 r_sign;
    logic [15:0]               r_heading;
    logic [15:0]               r_dt;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ACC_W-2:0]   r_t1;
    logic signed [ACC_W-2:0]   r_t2;
    logic signed [PE_W-1:0]    r_pe;
    logic signed [CORR_W-1:0]  r_corr;
    logic signed [DRV_W-1:0]   r_left_x;
    logic signed [DRV_W-1:0]   r_right_x;
    logic                      r_o_valid;
    logic signed [7:0]         r_left;
    logic signed [7:0]         r_right;
    logic signed [15:0]        r_err_out;
    t_mul_req                  r_req;
    t_mul_rsp                  w_rsp;

    logic signed [ERR_W-1:0]   w_diff;
    logic signed [ERR_W-1:0]   n_err;
    logic                      w_neg;
    logic                      w_pos;
    logic                      w_clr;
    logic signed [RND_W-1:0]   w_rnd;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [CORR_W-1:0]  w_corr;
    logic signed [DRV_W-1:0]   w_base;
    logic signed [15:0]        n_err16;

    function automatic logic signed [7:0] trunc_clip(input logic signed [DRV_W-1:0] x);
        logic signed [DRV_W-1:0] q;
        logic signed [7:0]       res;
        q = x >>> SH;
        if (x[DRV_W-1] && (x[SH-1:0] != '0)) begin
            q = q + DRV_W'(1);
        end
        if (q > LIM_P) begin
            res = 8'(LIM_P);
        end else if (q < LIM_N) begin
            res = 8'(LIM_N);
        end else begin
            res = 8'(q);
        end
        return res;
    endfunction

    hhpi_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_diff = {{(ERR_W-16){1'b0}}, r_heading} - {{(ERR_W-16){1'b0}}, r_start_heading};
        if (w_diff > HALF_S) begin
            n_err = w_diff - FULL_S;
        end else if (w_diff < -HALF_S) begin
            n_err = w_diff + FULL_S;
        end else begin
            n_err = w_diff;
        end
        w_neg = n_err[ERR_W-1];
        w_pos = !w_neg && (n_err != '0);
        w_clr = (w_neg && (r_sign == SIGN_POS)) || (w_pos && (r_sign == SIGN_NEG));

        w_rnd = round_sh8(w_rsp.product);
        w_acc = ACC_W'(r_t1) + ACC_W'(r_t2);
        if (w_acc > I_MAX) begin
            n_integ = INTEG_W'(I_MAX);
        end else if (w_acc < I_MIN) begin
            n_integ = INTEG_W'(I_MIN);
        end else begin
            n_integ = INTEG_W'(w_acc);
        end

        w_corr = (CORR_W'(r_pe) <<< 16) + CORR_W'(w_rsp.product);
        w_base = DRV_W'(r_base_speed) <<< SH;

        if (r_err > E_MAX) begin
            n_err16 = 16'(E_MAX);
        end else if (r_err < E_MIN) begin
            n_err16 = 16'(E_MIN);
        end else begin
            n_err16 = 16'(r_err);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_start_heading <= 16'd0;
            r_base_speed    <= 8'sd0;
            r_prop_gain     <= 10'd200;
            r_integ_gain    <= 8'd26;
            r_leak_factor   <= 9'd192;
            r_integ         <= '0;
            r_sign          <= SIGN_NONE;
            r_o_valid       <= 1'b0;
            r_req           <= '0;
        end else begin
            r_req.start <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_START_HEADING: r_start_heading <= i_cfg_data;
                    CFG_BASE_SPEED:    r_base_speed    <= i_cfg_data[7:0];
                    CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data[9:0];
                    CFG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data[7:0];
                    CFG_LEAK_FACTOR:   r_leak_factor   <= i_cfg_data[8:0];
                    default: ;
                endcase
            end

            if (r_o_valid && !i_stall && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_heading <= i_heading;
                        r_dt      <= i_dt_fraction;
                        r_state   <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err  <= n_err;
                    r_sign <= w_pos ? SIGN_POS : (w_neg ? SIGN_NEG : SIGN_NONE);
                    if (w_clr) begin
                        r_integ <= '0;
                    end
                    r_req.start <= 1'b1;
                    r_req.a     <= w_clr ? '0 : r_integ;
                    r_req.b     <= MUL_B_W'(r_leak_factor);
                    r_state     <= S_LEAK;
                end
                S_LEAK: begin
                    if (w_rsp.done) begin
                        r_t1        <= (ACC_W-1)'(w_rnd);
                        r_req.start <= 1'b1;
                        r_req.a     <= MUL_A_W'(r_err);
                        r_req.b     <= r_dt;
                        r_state     <= S_EDT;
                    end
                end
                S_EDT: begin
                    if (w_rsp.done) begin
                        r_t2    <= (ACC_W-1)'(w_rnd);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_integ     <= n_integ;
                    r_req.start <= 1'b1;
                    r_req.a     <= MUL_A_W'(r_err);
                    r_req.b     <= MUL_B_W'(r_prop_gain);
                    r_state     <= S_PROP;
                end
                S_PROP: begin
                    if (w_rsp.done) begin
                        r_pe        <= PE_W'(w_rsp.product);
                        r_req.start <= 1'b1;
                        r_req.a     <= r_integ;
                        r_req.b     <= MUL_B_W'(r_integ_gain);
                        r_state     <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    if (w_rsp.done) begin
                        r_corr  <= w_corr;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_left_x  <= w_base - DRV_W'(r_corr);
                    r_right_x <= w_base + DRV_W'(r_corr);
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_left    <= trunc_clip(r_left_x);
                        r_right   <= trunc_clip(r_right_x);
                        r_err_out <= n_err16;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_left_drive    = r_left;
    assign o_right_drive   = r_right;
    assign o_heading_error = r_err_out;
    assign o_cfg_ready     = 1'b1;

endmodule
